### hw/rtl/ecfh_pkg.sv
// ---------------------------------------------------------------------------
// ecfh_pkg
// shared types, codes and constants of the escaped command frame handler
// ---------------------------------------------------------------------------
`default_nettype none

package ecfh_pkg;

  localparam int FRAME_BYTES_DEF = 32;
  localparam int ARG_BYTES_DEF   = 32;

  // framing characters
  localparam logic [7:0] ESC_CHAR = 8'h5C;
  localparam logic [7:0] END_CHAR = 8'h00;

  // stub adc reading returned by the read function
  localparam logic [15:0] ADC_STUB = 16'd123;

  // command codes in frame byte 0
  localparam logic [7:0] CMD_ARGS = 8'd1;
  localparam logic [7:0] CMD_EXEC = 8'd2;

  // function indices in frame byte 1
  localparam logic [7:0] NUM_FUNCS = 8'd6;
  localparam logic [2:0] FN_VER0   = 3'd0;
  localparam logic [2:0] FN_LED    = 3'd2;
  localparam logic [2:0] FN_DAC1   = 3'd3;
  localparam logic [2:0] FN_DAC2   = 3'd4;
  localparam logic [2:0] FN_ADC    = 3'd5;

  // result kinds
  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_LED  = 2'd1;
  localparam logic [1:0] KIND_DAC1 = 2'd2;
  localparam logic [1:0] KIND_DAC2 = 2'd3;

  // index of the final beat of the adc reply
  localparam logic [1:0] ADC_LAST_STEP = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_F0,
    S_CMD,
    S_COPY,
    S_IDX,
    S_ARG,
    S_EMIT
  } st_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic [7:0]  led_value;
    logic [15:0] dac_low;
    logic [15:0] dac_high;
    logic        last;
  } res_t;

  // adc reply as escaped bytes: low byte needs no escape, the zero high
  // byte is preceded by an escape, then the end mark
  function automatic logic [7:0] adc_reply_byte(input logic [1:0] step);
    logic [7:0] b;
    b = END_CHAR;
    case (step)
      2'd0:    b = ADC_STUB[7:0];
      2'd1:    b = ESC_CHAR;
      2'd2:    b = ADC_STUB[15:8];
      default: b = END_CHAR;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/ecfh_ram.sv
// ---------------------------------------------------------------------------
// ecfh_ram
// generic single write, single read ram with registered read data
// ---------------------------------------------------------------------------
`default_nettype none

module ecfh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### hw/rtl/ecfh_store.sv
// ---------------------------------------------------------------------------
// ecfh_store
// byte store on a ram with per-entry valid bits; unwritten entries read zero
// ---------------------------------------------------------------------------
`default_nettype none

module ecfh_store #(
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [7:0]               wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [7:0]               rd_data
);

  logic [DEPTH-1:0] valid;
  logic             rd_valid;
  logic [7:0]       ram_q;

  ecfh_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      rd_valid <= valid[rd_addr];
    end
  end

  assign rd_data = rd_valid ? ram_q : 8'h00;

endmodule

`default_nettype wire

### hw/rtl/ecfh_out.sv
// ---------------------------------------------------------------------------
// ecfh_out
// result output register with valid/ready handshake
// ---------------------------------------------------------------------------
`default_nettype none

module ecfh_out
  import ecfh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load,
  input  wire res_t        res,
  output logic             free,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       kind,
  output logic [7:0]       tx_byte,
  output logic [7:0]       led_value,
  output logic [15:0]      dac_low,
  output logic [15:0]      dac_high,
  output logic             last
);

  res_t res_q;

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res;
    end
  end

  assign kind      = res_q.kind;
  assign tx_byte   = res_q.tx_byte;
  assign led_value = res_q.led_value;
  assign dac_low   = res_q.dac_low;
  assign dac_high  = res_q.dac_high;
  assign last      = res_q.last;

endmodule

`default_nettype wire

### hw/rtl/escaped_command_frame_handler_unit.sv
// ---------------------------------------------------------------------------
// escaped_command_frame_handler_unit
// serial byte-stuffed command frame decoder with frame and argument stores
// ---------------------------------------------------------------------------
// data, escape and empty-frame bytes are taken in idle; an argument load copies its bytes
//   with one ram read and write per cycle
// execute reads four argument bytes and emits one beat for led and dac, emits the
//   adc reply as four beats, and emits nothing for indices 0 and 1 or an unknown command;
//   output stalls hold the sequencer, and results show in the cycle after their load
// synchronous reset clears control state and store valid bits; no clearing pass
`default_nettype none

module escaped_command_frame_handler_unit
  import ecfh_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF,
  parameter int ARG_BYTES   = ARG_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        rx_valid,
  output logic             rx_ready,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       kind,
  output logic [7:0]       tx_byte,
  output logic [7:0]       led_value,
  output logic [15:0]      dac_low,
  output logic [15:0]      dac_high,
  output logic             last
);

  localparam int FA = $clog2(FRAME_BYTES);
  localparam int AA = $clog2(ARG_BYTES);
  localparam int CW = $clog2(FRAME_BYTES + 1);

  st_t state, state_next;

  // control registers
  logic          esc_pend;
  logic [CW-1:0] len;        // stored bytes of the frame in progress
  logic [CW-1:0] sz;         // length of the frame being executed
  logic [CW-1:0] cnt;        // argument copy position
  logic [1:0]    acnt;       // argument read position
  logic [1:0]    ecnt;       // result beat position
  logic [2:0]    fn;         // latched function index
  logic [3:0][7:0] arg_b;    // argument bytes 0..3

  // store ports
  logic          fr_wr_en;
  logic [FA-1:0] fr_wr_addr;
  logic [FA-1:0] fr_rd_addr;
  logic [7:0]    fr_q;
  logic          ar_wr_en;
  logic [AA-1:0] ar_wr_addr;
  logic [AA-1:0] ar_rd_addr;
  logic [7:0]    ar_q;

  // result path
  res_t          res;
  logic          res_load;
  logic          out_free;

  logic          acc;
  logic          store_c;
  logic          end_c;
  logic          copy_go;
  logic [2:0]    fn_c;
  logic [1:0]    n_last;

  // ---- input beat decode -----------------------------------------------
  assign acc     = rx_valid && rx_ready;
  // escaped byte or plain data byte goes to the frame store
  assign store_c = acc && (esc_pend || (rx_byte != END_CHAR && rx_byte != ESC_CHAR));
  assign end_c   = acc && !esc_pend && (rx_byte == END_CHAR);

  // copy runs while payload is left and the argument store has room
  assign copy_go = (CW'(cnt + CW'(1)) < sz) && (32'(cnt) < ARG_BYTES);

  // out-of-range function index falls back to the version index, which emits no result
  assign fn_c   = (fr_q < NUM_FUNCS) ? fr_q[2:0] : FN_VER0;
  assign n_last = (fn == FN_ADC) ? ADC_LAST_STEP : 2'd0;

  // ---- next state ------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (end_c && len != '0) begin
          state_next = S_F0;
        end
      end
      S_F0: begin
        state_next = S_CMD;
      end
      S_CMD: begin
        if (fr_q == CMD_ARGS) begin
          state_next = S_COPY;
        end else if (fr_q == CMD_EXEC) begin
          state_next = S_IDX;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_COPY: begin
        if (!copy_go) begin
          state_next = S_IDLE;
        end
      end
      S_IDX: begin
        if (fn_c == FN_LED || fn_c == FN_DAC1 || fn_c == FN_DAC2) begin
          state_next = S_ARG;
        end else if (fn_c == FN_ADC) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_ARG: begin
        if (acnt == 2'd3) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free && ecnt == n_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // ---- state outputs ---------------------------------------------------
  always_comb begin
    rx_ready   = 1'b0;
    fr_wr_en   = 1'b0;
    fr_wr_addr = FA'(len);
    fr_rd_addr = '0;
    ar_wr_en   = 1'b0;
    ar_wr_addr = AA'(cnt);
    ar_rd_addr = '0;
    res_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        rx_ready = 1'b1;
        // full store drops the byte
        fr_wr_en = store_c && (32'(len) < FRAME_BYTES);
      end
      S_F0: begin
        fr_rd_addr = '0;
      end
      S_CMD: begin
        // byte 1 is either the first payload byte or the function index
        fr_rd_addr = FA'(1);
      end
      S_COPY: begin
        // frame byte cnt+1 is on the read port, fetch the one after it
        ar_wr_en   = copy_go;
        fr_rd_addr = FA'(CW'(cnt + CW'(2)));
      end
      S_IDX: begin
        ar_rd_addr = '0;
      end
      S_ARG: begin
        ar_rd_addr = AA'(acnt) + AA'(1);
      end
      S_EMIT: begin
        res_load = out_free;
      end
      default: begin
        rx_ready = 1'b0;
      end
    endcase
  end

  // ---- result formatting -----------------------------------------------
  always_comb begin
    res           = '0;
    res.last      = (ecnt == n_last);
    case (fn)
      FN_LED: begin
        res.kind      = KIND_LED;
        res.led_value = arg_b[0];
      end
      FN_DAC1: begin
        res.kind     = KIND_DAC1;
        res.dac_low  = {arg_b[1], arg_b[0]};
        res.dac_high = {arg_b[3], arg_b[2]};
      end
      FN_DAC2: begin
        res.kind     = KIND_DAC2;
        res.dac_low  = {arg_b[1], arg_b[0]};
        res.dac_high = {arg_b[3], arg_b[2]};
      end
      default: begin
        res.kind    = KIND_TX;
        res.tx_byte = adc_reply_byte(ecnt);
      end
    endcase
  end

  // ---- registers -------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      esc_pend <= 1'b0;
      len      <= '0;
      sz       <= '0;
      cnt      <= '0;
      acnt     <= '0;
      ecnt     <= '0;
      fn       <= FN_VER0;
    end else begin
      state <= state_next;
      if (acc) begin
        esc_pend <= !esc_pend && (rx_byte == ESC_CHAR);
      end
      if (fr_wr_en) begin
        len <= CW'(len + CW'(1));
      end else if (end_c) begin
        len <= '0;
      end
      if (end_c) begin
        sz <= len;
      end
      if (state == S_CMD) begin
        cnt <= '0;
      end else if (state == S_COPY && copy_go) begin
        cnt <= CW'(cnt + CW'(1));
      end
      if (state == S_IDX) begin
        fn   <= fn_c;
        acnt <= '0;
        ecnt <= '0;
      end
      if (state == S_ARG) begin
        acnt <= acnt + 2'd1;
      end
      if (res_load) begin
        ecnt <= ecnt + 2'd1;
      end
    end
  end

  // argument bytes 0..3 fetched for led and dac writes
  always_ff @(posedge clk) begin
    if (state == S_ARG) begin
      arg_b[acnt] <= ar_q;
    end
  end

  // ---- stores and output stage -----------------------------------------
  ecfh_store #(
    .DEPTH (FRAME_BYTES)
  ) u_frame (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (fr_wr_en),
    .wr_addr (fr_wr_addr),
    .wr_data (rx_byte),
    .rd_addr (fr_rd_addr),
    .rd_data (fr_q)
  );

  ecfh_store #(
    .DEPTH (ARG_BYTES)
  ) u_args (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (ar_wr_en),
    .wr_addr (ar_wr_addr),
    .wr_data (fr_q),
    .rd_addr (ar_rd_addr),
    .rd_data (ar_q)
  );

  ecfh_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_load),
    .res       (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .tx_byte   (tx_byte),
    .led_value (led_value),
    .dac_low   (dac_low),
    .dac_high  (dac_high),
    .last      (last)
  );

  // ---- assertions ------------------------------------------------------
  // frame length never runs past the store
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    32'(len) <= FRAME_BYTES)
    else $error("frame length beyond store depth");

  // frame store is written only while taking input, never during a read pass
  a_frame_wr_idle: assert property (@(posedge clk) disable iff (rst)
    fr_wr_en |-> state == S_IDLE)
    else $error("frame store write outside idle");

  // argument writes and argument reads never overlap
  a_arg_wr_copy: assert property (@(posedge clk) disable iff (rst)
    ar_wr_en |-> state == S_COPY)
    else $error("argument store write outside copy");

  // a result is loaded only into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    res_load |-> out_free)
    else $error("result loaded over a pending beat");

  // the final result beat returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (res_load && res.last) |=> state == S_IDLE)
    else $error("sequencer busy after final result");

endmodule

`default_nettype wire
